### src/idle_sleep_lock_manager_top_defines.svh
// Assertion macros for the idle sleep lock manager checker.
// No dependencies; included by the checker file only.
`ifndef IDLE_SLEEP_LOCK_MANAGER_TOP_DEFINES_SVH
`define IDLE_SLEEP_LOCK_MANAGER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define ISLM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ISLM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/islm_pkg.sv
// Shared types, sizes and codes for the idle sleep lock manager.
// No dependencies; imported by every module of the block.
package islm_pkg;

   localparam int NUM_OWNERS  = 7;
   localparam int COUNT_WIDTH = 16;
   localparam int DELAY_WIDTH = 32;

   localparam int OWNER_IDX_W = (NUM_OWNERS > 1) ? $clog2(NUM_OWNERS) : 1;
   localparam int TOTAL_W     = COUNT_WIDTH + $clog2(NUM_OWNERS);

   localparam int CMD_W       = 3;
   localparam int OWNER_W     = 5;
   localparam int STATUS_W    = 3;
   localparam int WINDOW_W    = 32;
   localparam int REQ_DELAY_W = 32;
   localparam int LOCK_MASK_W = 32;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [WINDOW_W-1:0] ACTIVE_WINDOW_RESET = 32'd1000000;
   // register index, taken from byte address bit 2
   localparam logic REG_ACTIVE_WINDOW = 1'b0;

   localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ACTIVITY   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ACQUIRE    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RELEASE    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SET_ENABLE = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SCHEDULE   = 3'd6;
   localparam logic [CMD_W-1:0] CMD_STOP       = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID_OWNER  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ACQ_OVERFLOW   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RELEASE_UNHELD = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXPIRY_BLOCKED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EXPIRY_NO_DEEP = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0]       command;
      logic [OWNER_W-1:0]     owner;
      logic                   enable_value;
      logic [REQ_DELAY_W-1:0] delay_ticks;
      logic                   deep_sleep_allowed;
   } islm_req_type;

   typedef struct packed {
      logic                   sleep_request;
      logic                   blocked;
      logic [LOCK_MASK_W-1:0] lock_mask;
      logic                   check_armed;
      logic [STATUS_W-1:0]    status;
   } islm_result_type;

endpackage

### src/idle_sleep_lock_manager_top.sv
// A request passes from the input register into the result register and so to rsp_valid;
// while the result register is stalled, the request waits in the input register.
// Throughput: one request per cycle while the result is not stalled; the single update
// path between the two registers sets this figure. A stalled result leaves room for one
// more request in the input register, after which req_stall follows rsp_stall.
// Reset (synchronous, active high): no locks, not started, enabled, countdown disarmed,
// no pending delay, active window 1000000 ticks, both pipeline registers empty.
module idle_sleep_lock_manager_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [islm_pkg::CMD_W-1:0]         req_command,
   input  logic [islm_pkg::OWNER_W-1:0]       req_owner,
   input  logic                               req_enable_value,
   input  logic [islm_pkg::REQ_DELAY_W-1:0]   req_delay_ticks,
   input  logic                               req_deep_sleep_allowed,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_sleep_request,
   output logic                               rsp_blocked,
   output logic [islm_pkg::LOCK_MASK_W-1:0]   rsp_lock_mask,
   output logic                               rsp_check_armed,
   output logic [islm_pkg::STATUS_W-1:0]      rsp_status,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [islm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [islm_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [islm_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import islm_pkg::*;

   // Stage 1: input register holding one accepted request
   logic            in_valid_ff, in_valid_in;
   islm_req_type    in_req_ff;
   // Stage 2: result register feeding the rsp_ ports
   logic            out_valid_ff, out_valid_in;
   islm_result_type out_res_ff;

   islm_result_type core_res;
   logic [WINDOW_W-1:0] active_window;
   logic            accept;
   logic            fire;

   // A request moves from stage 1 into the core when the result register is
   // free or is being emptied in this very cycle.
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      // result stays while stalled, is replaced when a new one fires
      out_valid_in = fire || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff.command            <= req_command;
         in_req_ff.owner              <= req_owner;
         in_req_ff.enable_value       <= req_enable_value;
         in_req_ff.delay_ticks        <= req_delay_ticks;
         in_req_ff.deep_sleep_allowed <= req_deep_sleep_allowed;
      end
      if (fire) begin
         out_res_ff <= core_res;
      end
   end

   islm_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .active_window (active_window)
   );

   // lock counters and countdown; state advances only on fire
   islm_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .req           (in_req_ff),
      .active_window (active_window),
      .result        (core_res)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_sleep_request = out_res_ff.sleep_request;
   assign rsp_blocked       = out_res_ff.blocked;
   assign rsp_lock_mask     = out_res_ff.lock_mask;
   assign rsp_check_armed   = out_res_ff.check_armed;
   assign rsp_status        = out_res_ff.status;

endmodule

### src/islm_csr.sv
// APB-style configuration register (active window) for the lock manager.
// Depends on islm_pkg.
module islm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [islm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [islm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [islm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output logic [islm_pkg::WINDOW_W-1:0]   active_window
);
   import islm_pkg::*;

   logic [WINDOW_W-1:0] window_ff;
   logic [WINDOW_W-1:0] window_in;
   logic                wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_WINDOW);

   always_comb begin
      window_in = window_ff;
      if (wr_hit) begin
         window_in = WINDOW_W'(pwdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= ACTIVE_WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   assign prdata        = (paddr[2] == REG_ACTIVE_WINDOW) ? CSR_DATA_W'(window_ff) : '0;
   assign active_window = window_ff;

endmodule

### src/islm_core.sv
// Lock counters, sleep countdown state and per-request update logic.
// Depends on islm_pkg.
module islm_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  islm_pkg::islm_req_type        req,
   input  logic [islm_pkg::WINDOW_W-1:0] active_window,
   output islm_pkg::islm_result_type     result
);
   import islm_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] counts_ff [NUM_OWNERS];
   logic [COUNT_WIDTH-1:0] count_new;
   logic                   count_we;
   logic [NUM_OWNERS-1:0]  mask_ff, mask_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic                   started_ff, started_in;
   logic                   enabled_ff, enabled_in;
   logic                   armed_ff, armed_in;
   logic [DELAY_WIDTH-1:0] remaining_ff, remaining_in;
   logic                   pending_ff, pending_in;
   logic [DELAY_WIDTH-1:0] pending_delay_ff, pending_delay_in;

   logic [OWNER_IDX_W-1:0] idx;
   logic                   owner_ok;
   logic [COUNT_WIDTH-1:0] cur_count;
   logic                   do_sched;
   logic [DELAY_WIDTH-1:0] sched_delay;
   logic [DELAY_WIDTH-1:0] window_d;
   logic [STATUS_W-1:0]    status;
   logic                   sleep_req;

   assign idx       = req.owner[OWNER_IDX_W-1:0];
   assign owner_ok  = ({1'b0, req.owner} < (OWNER_W + 1)'(NUM_OWNERS));
   assign cur_count = counts_ff[idx];
   assign window_d  = DELAY_WIDTH'(active_window);

   always_comb begin
      started_in       = started_ff;
      enabled_in       = enabled_ff;
      armed_in         = armed_ff;
      remaining_in     = remaining_ff;
      pending_in       = pending_ff;
      pending_delay_in = pending_delay_ff;
      total_in         = total_ff;
      mask_in          = mask_ff;
      count_new        = cur_count;
      count_we         = 1'b0;
      do_sched         = 1'b0;
      sched_delay      = window_d;
      status           = ST_OK;
      sleep_req        = 1'b0;

      unique case (req.command)
         CMD_TICK: begin
            if (armed_ff) begin
               if (remaining_ff <= DELAY_WIDTH'(1)) begin
                  remaining_in = '0;
                  armed_in     = 1'b0;
                  if (!enabled_ff || (total_ff != '0)) begin
                     status = ST_EXPIRY_BLOCKED;
                  end else if (!req.deep_sleep_allowed) begin
                     status = ST_EXPIRY_NO_DEEP;
                  end else begin
                     sleep_req = 1'b1;
                  end
               end else begin
                  remaining_in = remaining_ff - DELAY_WIDTH'(1);
               end
            end
         end
         CMD_START: begin
            started_in       = 1'b1;
            pending_in       = 1'b0;
            pending_delay_in = '0;
            do_sched         = 1'b1;
         end
         CMD_ACTIVITY: begin
            if (!owner_ok) begin
               status = ST_INVALID_OWNER;
            end else begin
               pending_in       = 1'b0;
               pending_delay_in = '0;
               do_sched         = 1'b1;
            end
         end
         CMD_ACQUIRE: begin
            if (!owner_ok) begin
               status = ST_INVALID_OWNER;
            end else if (cur_count == COUNT_MAX) begin
               status = ST_ACQ_OVERFLOW;
            end else begin
               if (total_ff == '0) begin
                  armed_in = 1'b0;
               end
               count_new    = cur_count + COUNT_WIDTH'(1);
               count_we     = 1'b1;
               total_in     = total_ff + TOTAL_W'(1);
               mask_in[idx] = 1'b1;
            end
         end
         CMD_RELEASE: begin
            if (!owner_ok) begin
               status = ST_INVALID_OWNER;
            end else if (cur_count == '0) begin
               status = ST_RELEASE_UNHELD;
            end else begin
               count_new    = cur_count - COUNT_WIDTH'(1);
               count_we     = 1'b1;
               total_in     = total_ff - TOTAL_W'(1);
               mask_in[idx] = (cur_count != COUNT_WIDTH'(1));
               if (total_ff == TOTAL_W'(1)) begin
                  // last lock gone: rearm with the pending delay if one waits
                  sched_delay      = pending_ff ? pending_delay_ff : window_d;
                  pending_in       = 1'b0;
                  pending_delay_in = '0;
                  do_sched         = 1'b1;
               end
            end
         end
         CMD_SET_ENABLE: begin
            enabled_in       = req.enable_value;
            pending_in       = 1'b0;
            pending_delay_in = '0;
            if (!req.enable_value) begin
               armed_in = 1'b0;
            end else begin
               do_sched = 1'b1;
            end
         end
         CMD_SCHEDULE: begin
            pending_in       = 1'b1;
            pending_delay_in = DELAY_WIDTH'(req.delay_ticks);
            sched_delay      = DELAY_WIDTH'(req.delay_ticks);
            do_sched         = 1'b1;
         end
         CMD_STOP: begin
            pending_in       = 1'b0;
            pending_delay_in = '0;
            armed_in         = 1'b0;
         end
      endcase

      // arm only when started and enabled; held locks disarm instead
      if (do_sched && started_in && enabled_in) begin
         if (total_in != '0) begin
            armed_in = 1'b0;
         end else begin
            armed_in     = 1'b1;
            remaining_in = sched_delay;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_OWNERS; i++) begin
            counts_ff[i] <= '0;
         end
         mask_ff          <= '0;
         total_ff         <= '0;
         started_ff       <= 1'b0;
         enabled_ff       <= 1'b1;
         armed_ff         <= 1'b0;
         remaining_ff     <= '0;
         pending_ff       <= 1'b0;
         pending_delay_ff <= '0;
      end else if (fire) begin
         if (count_we) begin
            counts_ff[idx] <= count_new;
         end
         mask_ff          <= mask_in;
         total_ff         <= total_in;
         started_ff       <= started_in;
         enabled_ff       <= enabled_in;
         armed_ff         <= armed_in;
         remaining_ff     <= remaining_in;
         pending_ff       <= pending_in;
         pending_delay_ff <= pending_delay_in;
      end
   end

   always_comb begin
      result.sleep_request = sleep_req;
      result.blocked       = (total_in != '0);
      result.lock_mask     = LOCK_MASK_W'(mask_in);
      result.check_armed   = armed_in;
      result.status        = status;
   end

endmodule

### src/islm_checker.sv
// Port-level checks on the lock manager's result channel, bound to the top level.
// Depends on islm_pkg and idle_sleep_lock_manager_top_defines.svh.
`include "idle_sleep_lock_manager_top_defines.svh"

module islm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_sleep_request,
   input logic                             rsp_blocked,
   input logic [islm_pkg::LOCK_MASK_W-1:0] rsp_lock_mask,
   input logic                             rsp_check_armed,
   input logic [islm_pkg::STATUS_W-1:0]    rsp_status
);
   import islm_pkg::*;

   // a stalled result holds
   `ISLM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_lock_mask) && $stable(rsp_status) && $stable(rsp_sleep_request), "stalled result changed")

   // blocked exactly when some owner holds a lock
   `ISLM_ASSERT_NOW(a_blocked_mask, rsp_valid, rsp_blocked == (rsp_lock_mask != '0), "blocked disagrees with lock mask")

   // countdown never runs while locks are held
   `ISLM_ASSERT_NOW(a_armed_unblocked, rsp_valid && rsp_check_armed, !rsp_blocked, "countdown armed while blocked")

   // a sleep request comes from a clean expiry only
   `ISLM_ASSERT_NOW(a_sleep_clean, rsp_valid && rsp_sleep_request, !rsp_blocked && !rsp_check_armed && (rsp_status == ST_OK), "sleep request with locks, armed or bad status")

endmodule

bind idle_sleep_lock_manager_top islm_checker u_islm_checker (.*);
